// ===== src/fsne_pkg.sv =====
// ============================================================================
// fsne_pkg
// Shared types, constants and helpers for the short name encoder.
// ============================================================================
`default_nettype none

package fsne_pkg;

    // Default path depth before the component counter saturates.
    localparam int DEF_MAX_DEPTH = 64;

    // Depth of the job queue between the parser and the emitter.
    localparam int QUEUE_DEPTH = 4;

    // Field widths.
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 4;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int NAME_BYTES = 11;
    localparam int BASE_MAX   = 8;
    localparam int EXT_MAX    = 3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'd32;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_EXT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MULTI_DOT = 2'd2;

    // Last byte position of a name.
    localparam logic [POS_W-1:0] POS_LAST = 4'd10;

    // One finished component handed from the parser to the emitter.
    typedef struct packed {
        logic [NAME_BYTES-1:0][CHAR_W-1:0] name;
        logic [IDX_W-1:0]                  index;
        logic [STATUS_W-1:0]               status;
    } job_t;

    // Upper-case a letter a..z; other bytes pass unchanged.
    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/fsne_front.sv =====
// ============================================================================
// fsne_front
// Path parser: classifies each byte, builds the 11-byte name and hands one
// job per finished or malformed component to the queue.
// ============================================================================
`default_nettype none

module fsne_front
    import fsne_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic              end_of_path,
    output logic                   push,
    output job_t                   push_job
);

    localparam int CNT_W = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEPTH - 1);

    typedef enum logic [6:0] {
        PH_EMPTY = 7'b0000001,
        PH_NAME  = 7'b0000010,
        PH_DOT1  = 7'b0000100,
        PH_DOT2  = 7'b0001000,
        PH_EXT   = 7'b0010000,
        PH_FULL  = 7'b0100000,
        PH_SKIP  = 7'b1000000
    } phase_t;

    logic [NAME_BYTES-1:0][CHAR_W-1:0] buf_reg, buf_next, buf_mid;
    logic [POS_W-1:0]                  base_reg, base_next, base_mid;
    logic [1:0]                        ext_reg, ext_next, ext_mid;
    phase_t                            phase_reg, phase_next, phase_mid;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;

    logic                              is_dot;
    logic                              is_slash;
    logic                              finish;
    logic                              err_multi;
    logic [CHAR_W-1:0]                 upc;
    logic [IDX_W+CNT_W-1:0]            idx_wide;

    assign is_dot   = (char_code == CHAR_DOT);
    assign is_slash = (char_code == CHAR_SLASH);
    assign finish   = is_slash || end_of_path;
    assign upc      = upcase(char_code);
    assign idx_wide = {{IDX_W{1'b0}}, cnt_reg};

    // Apply the byte to the component being built.
    always_comb
    begin
        buf_mid   = buf_reg;
        base_mid  = base_reg;
        ext_mid   = ext_reg;
        phase_mid = phase_reg;
        err_multi = 1'b0;
        if (!is_slash)
        begin
            case (phase_reg)
                PH_EMPTY:
                begin
                    if (is_dot)
                    begin
                        buf_mid[0] = CHAR_DOT;
                        phase_mid  = PH_DOT1;
                    end
                    else
                    begin
                        buf_mid[0] = upc;
                        base_mid   = POS_W'(1);
                        phase_mid  = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (is_dot)
                    begin
                        phase_mid = PH_EXT;
                    end
                    else if (base_reg < POS_W'(BASE_MAX))
                    begin
                        buf_mid[base_reg] = upc;
                        base_mid          = base_reg + POS_W'(1);
                    end
                end
                PH_DOT1:
                begin
                    if (is_dot)
                    begin
                        buf_mid[1] = CHAR_DOT;
                        phase_mid  = PH_DOT2;
                    end
                    else
                    begin
                        // A single leading dot: blank name, byte opens the extension.
                        buf_mid[0]        = CHAR_SPACE;
                        buf_mid[BASE_MAX] = upc;
                        ext_mid           = 2'd1;
                        phase_mid         = PH_EXT;
                    end
                end
                PH_DOT2:
                begin
                    err_multi = 1'b1;
                    phase_mid = PH_SKIP;
                end
                PH_EXT:
                begin
                    if (is_dot)
                    begin
                        err_multi = 1'b1;
                        phase_mid = PH_SKIP;
                    end
                    else if (ext_reg == 2'(EXT_MAX))
                    begin
                        phase_mid = PH_FULL;
                    end
                    else
                    begin
                        buf_mid[POS_W'(BASE_MAX) + {2'b00, ext_reg}] = upc;
                        ext_mid = ext_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Close the component and form the job for the emitter.
    always_comb
    begin
        buf_next        = buf_mid;
        base_next       = base_mid;
        ext_next        = ext_mid;
        phase_next      = phase_mid;
        cnt_next        = cnt_reg;
        push            = 1'b0;
        push_job.name   = buf_mid;
        push_job.index  = idx_wide[IDX_W-1:0];
        push_job.status = STATUS_OK;
        if (err_multi)
        begin
            push            = in_fire;
            push_job.status = STATUS_MULTI_DOT;
        end
        if (finish && phase_mid != PH_EMPTY)
        begin
            if (phase_mid == PH_EXT && ext_mid == 2'd0)
            begin
                push            = in_fire;
                push_job.status = STATUS_NO_EXT;
            end
            else if (phase_mid != PH_SKIP)
            begin
                push = in_fire;
            end
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            buf_next   = {NAME_BYTES{CHAR_SPACE}};
            base_next  = '0;
            ext_next   = '0;
            phase_next = PH_EMPTY;
        end
        if (end_of_path)
        begin
            cnt_next = '0;
        end
    end

    // Parser state, updated on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= {NAME_BYTES{CHAR_SPACE}};
            base_reg  <= '0;
            ext_reg   <= '0;
            phase_reg <= PH_EMPTY;
            cnt_reg   <= '0;
        end
        else if (in_fire)
        begin
            buf_reg   <= buf_next;
            base_reg  <= base_next;
            ext_reg   <= ext_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/fsne_queue.sv =====
// ============================================================================
// fsne_queue
// Short job queue that decouples the parser from the name emitter.
// ============================================================================
`default_nettype none

module fsne_queue
    import fsne_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops in the same cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/fsne_back.sv =====
// ============================================================================
// fsne_back
// Name emitter: plays a queued job out as 11 name bytes, or as one error
// transfer, one transfer per cycle while the receiver is ready.
// ============================================================================
`default_nettype none

module fsne_back
    import fsne_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire job_t          head_job,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [23:0]        m_axis_tdata,
    output logic [STATUS_W-1:0] m_axis_tuser,
    output logic               m_axis_tlast
);

    job_t             job_reg;
    logic             busy_reg;
    logic [POS_W-1:0] pos_reg;
    logic             is_err;
    logic             last_item;
    logic             out_fire;
    logic [CHAR_W-1:0] name_byte;

    assign is_err    = (job_reg.status != STATUS_OK);
    assign last_item = is_err || (pos_reg == POS_LAST);
    assign out_fire  = busy_reg && m_axis_tready;
    assign pop       = head_valid && (!busy_reg || (out_fire && last_item));
    assign name_byte = is_err ? '0 : job_reg.name[pos_reg];

    // Output fields.
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {6'b0, job_reg.index, pos_reg, name_byte};
    assign m_axis_tuser  = job_reg.status;
    assign m_axis_tlast  = last_item;

    // Emission control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end
        else if (out_fire)
        begin
            if (last_item)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // Job held while it is played out.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/fat_short_name_encoder.sv =====
// ============================================================================
// fat_short_name_encoder
// Turns a byte stream of paths into 11-byte FAT 8.3 names, one per component.
// ============================================================================
// Usage:
//   The slave channel takes one path byte per transfer; tlast marks the last
//   byte of a path. A slash or the last byte closes a component.
//   The master channel gives one transfer per name byte, positions 0 to 10,
//   with tlast on position 10. A malformed component gives a single transfer
//   with a nonzero status in tuser, name byte and position zero, and tlast.
//   Input bytes are taken one per cycle while the four-entry job queue has
//   room. The emitter plays out one name byte per cycle (an error is a
//   single transfer) while the receiver is ready, so the sustained path
//   rate is one byte per cycle for components of 11 or more bytes.
//   A closing byte's job is registered in the queue, then in the emitter.
//   When the receiver stalls, the queue fills and then s_axis_tready drops;
//   no byte or result is lost.
//   Reset clears the parser to an empty component, the component count to
//   zero, and empties the queue; it takes effect at once.
// ============================================================================
`default_nettype none

module fat_short_name_encoder
    import fsne_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Path bytes.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] char_code
    input  wire logic                s_axis_tlast,   // end_of_path
    // Name bytes.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [23:0]              m_axis_tdata,   // [7:0] name_byte,
                                                     // [11:8] byte_position,
                                                     // [17:12] component_index
    output logic [STATUS_W-1:0]      m_axis_tuser,   // [1:0] status
    output logic                     m_axis_tlast    // last_of_name
);

    logic in_fire;
    logic push;
    job_t push_job;
    logic pop;
    logic q_full;
    logic head_valid;
    job_t head_job;

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Parser.
    fsne_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .char_code   (s_axis_tdata),
        .end_of_path (s_axis_tlast),
        .push        (push),
        .push_job    (push_job)
    );

    // Job queue.
    fsne_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Emitter.
    fsne_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // An error transfer is a single, final transfer at position zero.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_OK
            |-> m_axis_tlast && m_axis_tdata[11:8] == 4'd0 && m_axis_tdata[7:0] == 8'd0)
        else $error("error transfer is not a lone final transfer");

    // Within a name, positions advance by one and the component index holds.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
            |=> m_axis_tvalid
                && m_axis_tdata[11:8] == $past(m_axis_tdata[11:8]) + 4'd1
                && m_axis_tdata[17:12] == $past(m_axis_tdata[17:12]))
        else $error("name bytes out of sequence");

    // tlast on a good name falls exactly on position ten.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_OK
            |-> m_axis_tlast == (m_axis_tdata[11:8] == POS_LAST))
        else $error("tlast does not match the final name position");

    // A result cannot be on offer unless a job was queued before it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(head_valid))
        else $error("result appeared without a queued job");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for the FAT 8.3 short name encoder.
// ============================================================================
// Path bytes are sent on the slave stream. A behavioral predictor builds the
// expected 11-byte names and error results for each accepted transfer, and a
// checker compares every master transfer with the oldest expected one. The
// run covers directed corner cases, a path deep enough to saturate the
// component count, a long receiver hold that fills the job queue, and random
// paths under four idling mixes on both streams.
// ============================================================================

module tb_top;

    import fsne_pkg::*;

    // Parse state of the component being built.
    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_BASE,
        SEG_ONE_DOT,
        SEG_TWO_DOTS,
        SEG_EXT,
        SEG_EXT_FULL,
        SEG_DISCARD
    } seg_state_t;

    // One expected master transfer.
    typedef struct {
        logic [CHAR_W-1:0]   ch;
        logic [POS_W-1:0]    pos;
        logic [IDX_W-1:0]    idx;
        logic [STATUS_W-1:0] status;
        logic                last;
    } name_byte_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;

    // Predictor state.
    logic [CHAR_W-1:0] name_buf [NAME_BYTES];
    int                base_len;
    int                ext_len;
    seg_state_t        seg_state;
    int                comp_idx;
    name_byte_t        expected_names [$];

    // Stream pacing and run statistics.
    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold_cycles;
    int bytes_sent;
    int names_seen;
    int errors_seen;
    int mismatch_count;

    fat_short_name_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] to_upper(logic [CHAR_W-1:0] c);
        return (c >= CHAR_LC_A && c <= CHAR_LC_Z) ? c - CASE_DIFF : c;
    endfunction

    function automatic void clear_segment();
        foreach (name_buf[i])
        begin
            name_buf[i] = CHAR_SPACE;
        end
        base_len  = 0;
        ext_len   = 0;
        seg_state = SEG_IDLE;
    endfunction

    function automatic void expect_name_byte(logic [CHAR_W-1:0] ch, int pos,
                                             logic [STATUS_W-1:0] status,
                                             logic last);
        name_byte_t nb;
        nb.ch     = ch;
        nb.pos    = pos[POS_W-1:0];
        nb.idx    = comp_idx[IDX_W-1:0];
        nb.status = status;
        nb.last   = last;
        expected_names.push_back(nb);
    endfunction

    // Extension bytes past the third send the rest of the component to waste.
    function automatic void put_ext_char(logic [CHAR_W-1:0] c);
        if (ext_len >= EXT_MAX)
        begin
            seg_state = SEG_EXT_FULL;
        end
        else
        begin
            name_buf[BASE_MAX + ext_len] = to_upper(c);
            ext_len++;
        end
    endfunction

    // A closing slash or last byte emits the whole name, or one error result
    // for a trailing dot; a discarded component is only counted.
    function automatic void close_component();
        if (seg_state == SEG_IDLE)
        begin
            return;
        end
        if (seg_state == SEG_EXT && ext_len == 0)
        begin
            expect_name_byte('0, 0, STATUS_NO_EXT, 1'b1);
        end
        else if (seg_state != SEG_DISCARD)
        begin
            for (int i = 0; i < NAME_BYTES; i++)
            begin
                expect_name_byte(name_buf[i], i, STATUS_OK, i == NAME_BYTES - 1);
            end
        end
        if (comp_idx < DEF_MAX_DEPTH - 1)
        begin
            comp_idx++;
        end
        clear_segment();
    endfunction

    function automatic void predict_path_byte(logic [CHAR_W-1:0] c, logic last);
        logic is_dot;
        is_dot = (c == CHAR_DOT);
        if (c == CHAR_SLASH)
        begin
            close_component();
        end
        else
        begin
            case (seg_state)
                SEG_IDLE:
                begin
                    if (is_dot)
                    begin
                        name_buf[0] = CHAR_DOT;
                        seg_state   = SEG_ONE_DOT;
                    end
                    else
                    begin
                        name_buf[0] = to_upper(c);
                        base_len    = 1;
                        seg_state   = SEG_BASE;
                    end
                end
                SEG_BASE:
                begin
                    if (is_dot)
                    begin
                        seg_state = SEG_EXT;
                    end
                    else if (base_len < BASE_MAX)
                    begin
                        name_buf[base_len] = to_upper(c);
                        base_len++;
                    end
                end
                SEG_ONE_DOT:
                begin
                    if (is_dot)
                    begin
                        name_buf[1] = CHAR_DOT;
                        seg_state   = SEG_TWO_DOTS;
                    end
                    else
                    begin
                        // Leading-dot name: blank base, byte goes to extension.
                        name_buf[0] = CHAR_SPACE;
                        seg_state   = SEG_EXT;
                        put_ext_char(c);
                    end
                end
                SEG_TWO_DOTS:
                begin
                    expect_name_byte('0, 0, STATUS_MULTI_DOT, 1'b1);
                    seg_state = SEG_DISCARD;
                end
                SEG_EXT:
                begin
                    if (is_dot)
                    begin
                        expect_name_byte('0, 0, STATUS_MULTI_DOT, 1'b1);
                        seg_state = SEG_DISCARD;
                    end
                    else
                    begin
                        put_ext_char(c);
                    end
                end
                default:
                begin
                end
            endcase
            if (last)
            begin
                close_component();
            end
        end
        if (last)
        begin
            comp_idx = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    initial
    begin : check_results
        name_byte_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_names.size() == 0)
                begin
                    $error("unexpected name transfer: data 0x%0h, status %0d",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_names.pop_front();
                    check_field("name_byte", want.ch, m_axis_tdata[7:0]);
                    check_field("byte_position", want.pos, m_axis_tdata[11:8]);
                    check_field("component_index", want.idx, m_axis_tdata[17:12]);
                    check_field("status", want.status, m_axis_tuser);
                    check_field("last_of_name", want.last, m_axis_tlast);
                    if (want.last && want.status == STATUS_OK)
                    begin
                        names_seen++;
                    end
                    else if (want.status != STATUS_OK)
                    begin
                        errors_seen++;
                    end
                end
            end
        end
    end

    // Receiver ready: a requested hold is counted down first, then random stalls.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Entered and left at a falling edge; predicts at the accepting edge.
    task automatic send_byte(logic [7:0] c, logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_path_byte(c, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_path(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Stop offering and wait until every expected transfer has come out.
    task automatic wait_names_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_names.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_name_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            c = CHAR_LC_A + 8'($urandom_range(25));
        end
        else if (pick < 6)
        begin
            c = CHAR_LC_A - CASE_DIFF + 8'($urandom_range(25));
        end
        else if (pick < 7)
        begin
            c = 8'("0") + 8'($urandom_range(9));
        end
        else
        begin
            do
            begin
                c = 8'($urandom_range(255));
            end
            while (c == CHAR_SLASH || c == CHAR_DOT);
        end
        return c;
    endfunction

    // Mostly well-formed components, with dot names, overflows, extra dots,
    // empty components and raw noise mixed in.
    task automatic send_random_path();
        logic [7:0] path [$];
        int         parts;
        int         kind;
        int         blen;
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++)
        begin
            if ($urandom_range(7) == 0)
            begin
                path.push_back(CHAR_SLASH);
            end
            kind = $urandom_range(19);
            if (kind == 0)
            begin
                path.push_back(CHAR_DOT);
            end
            else if (kind == 1)
            begin
                path.push_back(CHAR_DOT);
                path.push_back(CHAR_DOT);
                if ($urandom_range(2) == 0)
                begin
                    path.push_back(8'($urandom_range(255)));
                end
            end
            else if (kind == 2)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    path.push_back(8'($urandom_range(255)));
                end
            end
            else if (kind == 3)
            begin
                path.push_back(CHAR_DOT);
                repeat ($urandom_range(1, 4))
                begin
                    path.push_back(random_name_char());
                end
            end
            else
            begin
                blen = (kind == 4) ? $urandom_range(9, 12) : $urandom_range(1, 8);
                repeat (blen)
                begin
                    path.push_back(random_name_char());
                end
                if ($urandom_range(3) != 0)
                begin
                    path.push_back(CHAR_DOT);
                    repeat ($urandom_range(0, 4))
                    begin
                        path.push_back(random_name_char());
                    end
                    if ($urandom_range(9) == 0)
                    begin
                        path.push_back(CHAR_DOT);
                        path.push_back(random_name_char());
                    end
                end
            end
            if (p < parts - 1 || $urandom_range(4) == 0)
            begin
                path.push_back(CHAR_SLASH);
            end
        end
        foreach (path[i])
        begin
            send_byte(path[i], i == path.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Dot names, a slash as the last byte, letter case bounds, extra dots,
    // both overflows, zero and all-ones bytes, and a trailing dot.
    task automatic test_directed_paths();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_path("./../");
        send_path("..q/`{az.b.c");
        send_path("abcdefghi.jklm.");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_DOT, 1'b1);
        wait_names_drained();
    endtask

    // More components than the counter can count, then a fresh path.
    task automatic test_deep_path();
        for (int i = 0; i < DEF_MAX_DEPTH + 6; i++)
        begin
            send_byte(CHAR_LC_A + 8'(i % 26), 1'b0);
            send_byte(CHAR_SLASH, i == DEF_MAX_DEPTH + 5);
        end
        send_path("z.y");
        wait_names_drained();
    endtask

    // The receiver holds off while short names keep coming, so the job
    // queue fills and the input stalls.
    task automatic test_input_stall();
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 300;
        repeat (25)
        begin
            send_byte(random_name_char(), 1'b0);
            send_byte(CHAR_SLASH, 1'b0);
        end
        send_byte(random_name_char(), 1'b1);
        wait_names_drained();
    endtask

    task automatic test_random_paths(int src_pct, int sink_pct, int count);
        int start;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = bytes_sent;
        while (bytes_sent - start < count)
        begin
            send_random_path();
        end
        wait_names_drained();
    endtask

    initial
    begin : run_tests
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 0;
        bytes_sent       = 0;
        names_seen       = 0;
        errors_seen      = 0;
        mismatch_count   = 0;
        comp_idx         = 0;
        clear_segment();
        repeat (9)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_paths();
        test_deep_path();
        test_input_stall();
        test_random_paths(0, 0, 45);
        test_random_paths(51, 0, 45);
        test_random_paths(0, 51, 45);
        test_random_paths(37, 37, 45);

        wait_names_drained();
        repeat (20)
        begin
            @(posedge clk);
        end
        if (expected_names.size() != 0)
        begin
            $error("%0d expected name transfers never arrived", expected_names.size());
            mismatch_count++;
        end

        $display("Covered %0d path bytes giving %0d names and %0d error results,",
                 bytes_sent, names_seen, errors_seen);
        $display("with a saturating deep path, a long receiver hold and four idling mixes.");
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fsne_pkg.sv
src/fsne_front.sv
src/fsne_queue.sv
src/fsne_back.sv
src/fat_short_name_encoder.sv
tb/tb_top.sv
